// ===== sv/etfs_pkg.sv =====
// Shared constants and types of the event tally and first-seen filter.
package etfs_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int SITE_COUNT  = 18;

	localparam int TABLE_AW  = $clog2(TABLE_DEPTH);
	localparam int FILL_W    = TABLE_AW + 1;
	localparam int SITE_AW   = (SITE_COUNT > 1) ? $clog2(SITE_COUNT) : 1;
	localparam int INDEX_W   = 5;
	localparam int TAG_W     = 16;
	localparam int KEY_W     = 32;
	localparam int COUNT_W   = 32;

	localparam logic [TAG_W-1:0] FAIL_TAG_BASE = 16'h1000;

	typedef struct packed {
		logic               counted;
		logic [INDEX_W-1:0] counter_index;
		logic               succeeded;
		logic [TAG_W-1:0]   site_tag;
		logic [KEY_W-1:0]   key_a;
		logic [KEY_W-1:0]   key_b;
	} evt_t;

	typedef struct packed {
		logic               first_seen;
		logic               table_full;
		logic [COUNT_W-1:0] ok_count;
		logic [COUNT_W-1:0] bad_count;
	} res_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;
	} seen_entry_t;

	typedef struct packed {
		logic [COUNT_W-1:0] ok_count;
		logic [COUNT_W-1:0] bad_count;
	} tally_pair_t;

	typedef struct packed {
		logic        done;
		tally_pair_t counts;
	} tally_res_t;

	typedef struct packed {
		logic done;
		logic first_seen;
		logic busy;
		logic table_full;
	} srch_res_t;

endpackage

// ===== sv/etfs_ram.sv =====
// Generic synchronous RAM with one write port and one registered read port.
module etfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/etfs_tally.sv =====
// Per-site success and failure counters kept in a RAM with read-modify-write.
module etfs_tally
	import etfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [INDEX_W-1:0] index,
	input  logic               succeeded,
	output tally_res_t         res
);

	logic [SITE_AW-1:0]    idx_q;
	logic                  ok_q;
	logic                  pend_q;
	logic [SITE_COUNT-1:0] valid_q;
	tally_pair_t           rd_data;
	tally_pair_t           cur;
	tally_pair_t           upd;

	always_ff @(posedge clk) begin
		if (start) begin
			idx_q <= SITE_AW'(index);
			ok_q  <= succeeded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			valid_q <= '0;
		end else begin
			pend_q <= start;
			if (pend_q) begin
				valid_q[idx_q] <= 1'b1;
			end
		end
	end

	// Entries never written since reset read as zero.
	always_comb begin
		cur = valid_q[idx_q] ? rd_data : '0;
		upd = cur;
		if (ok_q) begin
			upd.ok_count = cur.ok_count + COUNT_W'(1);
		end else begin
			upd.bad_count = cur.bad_count + COUNT_W'(1);
		end
	end

	etfs_ram #(
		.WIDTH($bits(tally_pair_t)),
		.DEPTH(SITE_COUNT)
	) u_cnt_ram (
		.clk  (clk),
		.we   (pend_q),
		.waddr(idx_q),
		.wdata(upd),
		.re   (start),
		.raddr(SITE_AW'(index)),
		.rdata(rd_data)
	);

	assign res.done   = pend_q;
	assign res.counts = upd;

endmodule

// ===== sv/etfs_search.sv =====
// Fill-ordered seen table with a linear search and append on miss while space remains.
module etfs_search
	import etfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  seen_entry_t key,
	output srch_res_t   res
);

	seen_entry_t         key_q;
	logic                active_q;
	logic [FILL_W-1:0]   idx_q;
	logic [FILL_W-1:0]   fill_q;
	logic                cmp_s1;
	logic                hit_q;
	logic                rd_en;
	logic                finish;
	logic                append;
	seen_entry_t         rd_data;

	assign rd_en  = active_q && (idx_q < fill_q);
	assign finish = active_q && !rd_en && !cmp_s1;
	assign append = finish && !hit_q && (fill_q < FILL_W'(TABLE_DEPTH));

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			fill_q   <= '0;
			cmp_s1   <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			cmp_s1 <= rd_en;
			if (start) begin
				active_q <= 1'b1;
				idx_q    <= '0;
				hit_q    <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + FILL_W'(1);
				end
				if (cmp_s1 && (rd_data == key_q)) begin
					hit_q <= 1'b1;
				end
				if (finish) begin
					active_q <= 1'b0;
				end
				if (append) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	etfs_ram #(
		.WIDTH($bits(seen_entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_seen_ram (
		.clk  (clk),
		.we   (append),
		.waddr(fill_q[TABLE_AW-1:0]),
		.wdata(key_q),
		.re   (rd_en),
		.raddr(idx_q[TABLE_AW-1:0]),
		.rdata(rd_data)
	);

	assign res.done       = finish;
	assign res.first_seen = append;
	assign res.busy       = active_q;
	assign res.table_full = (fill_q == FILL_W'(TABLE_DEPTH));

endmodule

// ===== sv/event_tally_first_seen_filter.sv =====
// Event tally with per-site counters and a first-seen filter; top level.
// Sites past the last counter go straight to the result, counted successes only update
// their counter, uncounted events search the seen table and counted failures do both, the
// search after the counter update. The seen table (fill up to 256) is a RAM read one entry
// per cycle. Events are handled one at a time; a new event is taken once the previous result
// is loaded. Reset clears fill level and all counters.
module event_tally_first_seen_filter
	import etfs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic evt_valid,
	output logic evt_stall,
	input  evt_t evt,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_TALLY  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t             state_q;
	evt_t               item_q;
	logic               first_q;
	tally_pair_t        counts_q;
	res_t               res_q;
	logic               res_valid_q;
	logic               evt_xfer;
	logic               in_range;
	logic               tally_start;
	logic               srch_start;
	logic               res_load;
	seen_entry_t        srch_key;
	tally_res_t         tally_res;
	srch_res_t          srch_res;

	// An event is taken only in idle; the result register lets the next event in
	// while the previous result still waits for its transfer.
	assign evt_stall = (state_q != ST_IDLE);
	assign evt_xfer  = evt_valid && !evt_stall;
	assign in_range  = (32'(evt.counter_index) < SITE_COUNT);

	assign tally_start = evt_xfer && evt.counted && in_range;

	// Uncounted events search straight away with their own tag; counted failures
	// search after their counter update, with the fail tag of their site.
	assign srch_start = (evt_xfer && !evt.counted) ||
		(tally_res.done && !item_q.succeeded);

	always_comb begin
		if (state_q == ST_IDLE) begin
			srch_key.tag = evt.site_tag;
			srch_key.key_a = evt.key_a;
			srch_key.key_b = evt.key_b;
		end else begin
			srch_key.tag = FAIL_TAG_BASE + TAG_W'(item_q.counter_index);
			srch_key.key_a = item_q.key_a;
			srch_key.key_b = item_q.key_b;
		end
	end

	assign res_load = (state_q == ST_RESULT) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk) begin
		if (evt_xfer) begin
			item_q <= evt;
		end
		if (res_load) begin
			res_q.first_seen <= first_q;
			res_q.table_full <= srch_res.table_full;
			res_q.ok_count   <= counts_q.ok_count;
			res_q.bad_count  <= counts_q.bad_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			counts_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (evt_xfer) begin
						first_q  <= 1'b0;
						counts_q <= '0;
						if (!evt.counted) begin
							state_q <= ST_SEARCH;
						end else if (in_range) begin
							state_q <= ST_TALLY;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_TALLY: begin
					if (tally_res.done) begin
						counts_q <= tally_res.counts;
						state_q  <= item_q.succeeded ? ST_RESULT : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						first_q <= srch_res.first_seen;
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	etfs_tally u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tally_start),
		.index    (evt.counter_index),
		.succeeded(evt.succeeded),
		.res      (tally_res)
	);

	etfs_search u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.start (srch_start),
		.key   (srch_key),
		.res   (srch_res)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_search_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		srch_start |-> !srch_res.busy)
		else $error("search started while a search is running");

	a_full_stays: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.table_full |=> srch_res.table_full)
		else $error("seen table fill level went down");

	a_tally_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		tally_res.done |-> (state_q == ST_TALLY))
		else $error("counter update finished outside the tally state");

	a_search_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == ST_SEARCH))
		else $error("search finished outside the search state");
`endif

endmodule

// ===== tb/event_tally_first_seen_filter_tb.sv =====
// Self-checking testbench for the event tally and first-seen filter.
module event_tally_first_seen_filter_tb;
	import etfs_pkg::*;

	// Idle patterns applied to the two channels, rotated as the run goes on.
	typedef enum int {
		PH_NO_IDLE,
		PH_SENDER_IDLE,
		PH_RECEIVER_STALL,
		PH_BOTH_IDLE
	} idle_phase_t;

	localparam int RANDOM_EVENTS = 1450;
	localparam int PHASE_LEN     = 120;
	// A full-table search walks all TABLE_DEPTH entries of the seen table.
	localparam int DRAIN_CYCLES  = TABLE_DEPTH + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic evt_valid = 1'b0;
	logic evt_stall;
	evt_t evt = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	event_tally_first_seen_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #4 clk = ~clk;

	// Events waiting to be driven, and results the block still owes us.
	evt_t        pending_events[$];
	res_t        expected_results[$];
	// Every triple that went through a dedup check, kept so that the random
	// part can send it again and hit the table.
	seen_entry_t triple_history[$];

	// Our own copy of the block's state.
	seen_entry_t        seen_model[TABLE_DEPTH];
	int                 seen_fill = 0;
	logic [COUNT_W-1:0] ok_tally[SITE_COUNT];
	logic [COUNT_W-1:0] bad_tally[SITE_COUNT];

	int          issued_evts = 0;
	int          accepted_evts = 0;
	int          checked_results = 0;
	int          first_seen_reports = 0;
	int          full_reports = 0;
	int          mismatch_count = 0;
	idle_phase_t idle_phase = PH_NO_IDLE;

	initial begin
		for (int i = 0; i < SITE_COUNT; i++) begin
			ok_tally[i] = '0;
			bad_tally[i] = '0;
		end
	end

	// Searches the filled part of the table in fill order. A miss is appended
	// and reported as first seen, unless the table is already full.
	function automatic logic lookup_or_insert(logic [TAG_W-1:0] tag,
			logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
		seen_entry_t probe;
		probe = '{tag: tag, key_a: ka, key_b: kb};
		for (int i = 0; i < seen_fill; i++) begin
			if (seen_model[i] == probe)
				return 1'b0;
		end
		if (seen_fill >= TABLE_DEPTH)
			return 1'b0;
		seen_model[seen_fill] = probe;
		seen_fill++;
		return 1'b1;
	endfunction

	// Updates the model for one accepted event and returns the result the block
	// must produce for it. Counted failures are checked under their site's fail
	// tag; counted successes are only tallied; out-of-range sites are neither counted nor checked.
	function automatic res_t predict_result(evt_t e);
		res_t r;
		r = '0;
		if (e.counted) begin
			if (e.counter_index < SITE_COUNT) begin
				if (e.succeeded) begin
					ok_tally[e.counter_index] = ok_tally[e.counter_index] + 1'b1;
				end else begin
					bad_tally[e.counter_index] = bad_tally[e.counter_index] + 1'b1;
					r.first_seen = lookup_or_insert(FAIL_TAG_BASE + e.counter_index,
						e.key_a, e.key_b);
				end
				r.ok_count  = ok_tally[e.counter_index];
				r.bad_count = bad_tally[e.counter_index];
			end
		end else begin
			r.first_seen = lookup_or_insert(e.site_tag, e.key_a, e.key_b);
		end
		r.table_full = (seen_fill >= TABLE_DEPTH);
		return r;
	endfunction

	function automatic void check_field(string name, logic [COUNT_W-1:0] want,
			logic [COUNT_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// Builds one event, queues it, and remembers the triple it will look up, if any.
	task automatic queue_event(bit cnt, int idx, bit ok, int tag,
			logic [KEY_W-1:0] ka, logic [KEY_W-1:0] kb);
		evt_t e;
		e.counted       = cnt;
		e.counter_index = idx[INDEX_W-1:0];
		e.succeeded     = ok;
		e.site_tag      = tag[TAG_W-1:0];
		e.key_a         = ka;
		e.key_b         = kb;
		pending_events.push_back(e);
		if (!cnt)
			triple_history.push_back('{tag: e.site_tag, key_a: ka, key_b: kb});
		else if (idx < SITE_COUNT && !ok)
			triple_history.push_back('{tag: FAIL_TAG_BASE + e.counter_index,
				key_a: ka, key_b: kb});
	endtask

	// Keys are often drawn from a tiny range so that fresh events still collide
	// with stored ones now and then.
	function automatic logic [KEY_W-1:0] fresh_key();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 7);
		return $urandom;
	endfunction

	function automatic int fresh_tag();
		int pick;
		pick = $urandom_range(0, 3);
		if (pick == 0)
			return FAIL_TAG_BASE + $urandom_range(0, SITE_COUNT - 1);
		if (pick == 1)
			return $urandom_range(0, 15);
		return $urandom_range(0, 16'hFFFF);
	endfunction

	// Driver. Inputs change on the falling edge. An event stays on the bus until
	// the monitor has counted its transfer; only then is the next one taken
	// from the queue, or the channel left idle.
	always @(negedge clk) begin
		int idle_pct;
		if (arst_n) begin
			idle_phase = idle_phase_t'((issued_evts / PHASE_LEN) % 4);
			idle_pct = (idle_phase == PH_SENDER_IDLE) ? 65 :
				(idle_phase == PH_BOTH_IDLE) ? 30 : 0;
			if (!(evt_valid && accepted_evts != issued_evts)) begin
				if (pending_events.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					evt <= pending_events.pop_front();
					evt_valid <= 1'b1;
					issued_evts++;
				end else begin
					evt_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, drawn fresh each cycle from the current idle pattern.
	always @(negedge clk) begin
		int stall_pct;
		stall_pct = (idle_phase == PH_RECEIVER_STALL) ? 65 :
			(idle_phase == PH_BOTH_IDLE) ? 30 : 0;
		res_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Monitor. On the rising edge an input transfer feeds the model and an output
	// transfer is compared against the oldest expected result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (evt_valid && !evt_stall) begin
				expected_results.push_back(predict_result(evt));
				accepted_evts++;
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with nothing expected, actual %0h", $time, res);
				end else begin
					want = expected_results.pop_front();
					check_field("first_seen", want.first_seen, res.first_seen);
					check_field("table_full", want.table_full, res.table_full);
					check_field("ok_count", want.ok_count, res.ok_count);
					check_field("bad_count", want.bad_count, res.bad_count);
					checked_results++;
					if (res.first_seen)
						first_seen_reports++;
					if (res.table_full)
						full_reports++;
				end
			end
		end
	end

	initial begin
		int          sel;
		int          idx;
		seen_entry_t old;

		// Directed part: field extremes, each kind of event, repeats, the shared
		// tag range between uncounted queries and site failures, and sites that
		// lie past the last counter.
		queue_event(0, 0, 0, 16'h0000, 32'h0, 32'h0);
		queue_event(0, 0, 0, 16'h0000, 32'h0, 32'h0);
		queue_event(0, 31, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_event(1, 0, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		queue_event(1, SITE_COUNT - 1, 1, 16'h0000, 32'h0, 32'hFFFF_FFFF);
		queue_event(1, 0, 0, 16'hFFFF, 32'h0, 32'h0);
		queue_event(1, 0, 0, 16'h0000, 32'h0, 32'h0);
		queue_event(1, SITE_COUNT - 1, 0, 16'h0000, 32'hFFFF_FFFF, 32'h0);
		// An uncounted query that reuses the last site's failure tag must hit.
		queue_event(0, 0, 0, FAIL_TAG_BASE + SITE_COUNT - 1, 32'hFFFF_FFFF, 32'h0);
		queue_event(0, 0, 0, FAIL_TAG_BASE + 5, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_event(1, 5, 0, 16'h0000, 32'h1234_5678, 32'h9ABC_DEF0);
		queue_event(1, 5, 1, 16'h0000, 32'h1234_5678, 32'h9ABC_DEF0);
		// Sites past the last counter are neither counted nor searched.
		queue_event(1, SITE_COUNT, 0, 16'h0000, 32'hDEAD_0001, 32'h1);
		queue_event(1, 31, 1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_event(1, SITE_COUNT, 1, 16'h0000, 32'h0, 32'h0);
		queue_event(1, 31, 0, 16'h5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		queue_event(0, 31, 1, 16'hA5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
		queue_event(1, 16, 0, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_event(1, 16, 0, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// Random part. Roughly half the events bring a new triple, so the table
		// fills early and the rest of the run also covers the full-table case.
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			sel = $urandom_range(0, 99);
			idx = $urandom_range(0, SITE_COUNT - 1);
			if (sel < 35) begin
				// Send an earlier triple again, either as a site failure or as a
				// plain query under the same tag.
				old = triple_history[$urandom_range(0, triple_history.size() - 1)];
				if (old.tag >= FAIL_TAG_BASE && old.tag < FAIL_TAG_BASE + SITE_COUNT
						&& $urandom_range(0, 1))
					queue_event(1, old.tag - FAIL_TAG_BASE, 0, $urandom_range(0, 16'hFFFF),
						old.key_a, old.key_b);
				else
					queue_event(0, $urandom_range(0, 31), $urandom_range(0, 1), old.tag,
						old.key_a, old.key_b);
			end else if (sel < 47) begin
				queue_event(1, idx, 1, $urandom_range(0, 16'hFFFF), $urandom, $urandom);
			end else if (sel < 52) begin
				queue_event(1, $urandom_range(SITE_COUNT, 31), $urandom_range(0, 1),
					$urandom_range(0, 16'hFFFF), $urandom, $urandom);
			end else if (sel < 76) begin
				queue_event(1, idx, 0, $urandom_range(0, 16'hFFFF), fresh_key(), fresh_key());
			end else begin
				queue_event(0, $urandom_range(0, 31), $urandom_range(0, 1), fresh_tag(),
					fresh_key(), fresh_key());
			end
		end

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() > 0 || accepted_evts != issued_evts
				|| expected_results.size() > 0)
			@(posedge clk);
		// Give a stray extra result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results for %0d events; %0d first-seen reports.",
			checked_results, accepted_evts, first_seen_reports);
		$display("Final table fill %0d of %0d; %0d results reported a full table.",
			seen_fill, TABLE_DEPTH, full_reports);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: a correct run finishes well before this time limit.
	initial begin
		#16000000;
		$display("simulation failed");
		$finish;
	end

endmodule
